>>> rtl/base32_byte_encoder_unit_assert.svh
// Assertion macros used by the checker file of the base32 byte encoder.
`ifndef BASE32_BYTE_ENCODER_UNIT_ASSERT_SVH
`define BASE32_BYTE_ENCODER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define B32_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define B32_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/b32enc_pkg.sv
// Package with the types, constants and alphabet function of the base32 encoder.
`default_nettype none

package b32enc_pkg;

    localparam int unsigned CodeW  = 5;
    localparam int unsigned SlotN  = 3;
    localparam int unsigned AccW   = 12;
    localparam int unsigned WinW   = CodeW * SlotN;

    typedef logic [CodeW-1:0] t_code;

    // One byte's worth of work: up to three 5-bit codes, slot 0 goes out first.
    typedef struct packed {
        t_code [SlotN-1:0] codes;
        logic  [1:0]       num;
        logic              last;
    } t_grp;

    // Status of the queue as seen by the front and back parts.
    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    // Maps a 5-bit code to its ASCII character: A-Z for 0..25, 2-7 for 26..31.
    function automatic logic [7:0] f_ascii(input t_code code);
        logic [7:0] wide;
        wide = {3'b000, code};
        if (code < 5'd26) begin
            return 8'h41 + wide;
        end else begin
            return 8'h18 + wide;
        end
    endfunction

endpackage

`default_nettype wire

>>> rtl/b32enc_if.sv
// Channel interfaces for the byte input and the symbol output of the base32 encoder.
`default_nettype none

interface b32enc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       final_byte;

    modport source (output valid, output data_byte, output final_byte, input ready);
    modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface b32enc_sym_if;
    logic       valid;
    logic       ready;
    logic [7:0] symbol;
    logic       last_symbol;

    modport source (output valid, output symbol, output last_symbol, input ready);
    modport sink   (input valid, input symbol, input last_symbol, output ready);
endinterface

`default_nettype wire

>>> rtl/b32enc_front.sv
// Front part: merges each byte with the leftover bits and splits it into 5-bit codes.
`default_nettype none

module b32enc_front import b32enc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    b32enc_byte_if.sink        i_byte,
    input  t_qstat             i_qstat,
    output logic               o_push,
    output t_grp               o_grp
);

    logic [3:0]      r_bits;
    logic [2:0]      r_cnt;
    logic [3:0]      n_bits;
    logic [2:0]      n_cnt;

    logic [2:0]      cnt_c;
    logic [3:0]      keep;
    logic [AccW-1:0] acc;
    logic [3:0]      nbits;
    logic [3:0]      shamt;
    logic [WinW-1:0] win;
    logic            two;
    logic [2:0]      rem;
    logic [4:0]      rem_mask;
    logic            accept;

    always_comb begin
        cnt_c    = (r_cnt > 3'd4) ? 3'd4 : r_cnt;
        keep     = r_bits & 4'((5'b00001 << cnt_c) - 5'd1);
        acc      = {keep, i_byte.data_byte};
        nbits    = 4'd8 + {1'b0, cnt_c};
        shamt    = 4'd12 - nbits;
        // Left-align the valid bits in a 15-bit window; the pad bits come in as zeros.
        win      = {acc, 3'b000} << shamt;
        two      = (nbits >= 4'd10);
        rem      = two ? 3'(nbits - 4'd10) : 3'(nbits - 4'd5);
        rem_mask = (5'b00001 << rem) - 5'd1;

        o_grp.codes[0] = win[14:10];
        o_grp.codes[1] = win[9:5];
        o_grp.codes[2] = win[4:0];
        o_grp.num      = (two ? 2'd2 : 2'd1)
                         + {1'b0, (i_byte.final_byte && (rem != 3'd0))};
        o_grp.last     = i_byte.final_byte;

        accept         = i_byte.valid && !i_qstat.full;
        i_byte.ready   = !i_qstat.full;
        o_push         = accept;

        if (i_byte.final_byte) begin
            n_bits = 4'd0;
            n_cnt  = 3'd0;
        end else begin
            n_bits = acc[3:0] & rem_mask[3:0];
            n_cnt  = rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits <= 4'd0;
            r_cnt  <= 3'd0;
        end else if (accept) begin
            r_bits <= n_bits;
            r_cnt  <= n_cnt;
        end
    end

endmodule

`default_nettype wire

>>> rtl/b32enc_fifo.sv
// Small queue of code groups between the front and back parts.
`default_nettype none

module b32enc_fifo import b32enc_pkg::*; #(
    parameter int unsigned Depth = 2
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_grp   i_grp,
    input  logic   i_pop,
    output t_grp   o_head,
    output t_qstat o_qstat
);

    localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int unsigned CntW = $clog2(Depth + 1);

    t_grp            mem [Depth];
    logic [PtrW-1:0] r_wr;
    logic [PtrW-1:0] r_rd;
    logic [CntW-1:0] r_num;
    logic [PtrW-1:0] n_wr;
    logic [PtrW-1:0] n_rd;
    logic            do_push;
    logic            do_pop;

    always_comb begin
        o_qstat.full  = (r_num == CntW'(Depth));
        o_qstat.empty = (r_num == '0);
        o_head        = mem[r_rd];
        do_push       = i_push && !o_qstat.full;
        do_pop        = i_pop && !o_qstat.empty;
        n_wr          = (r_wr == PtrW'(Depth - 1)) ? '0 : r_wr + 1'b1;
        n_rd          = (r_rd == PtrW'(Depth - 1)) ? '0 : r_rd + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            mem[r_wr] <= i_grp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_num <= '0;
        end else begin
            if (do_push) begin
                r_wr <= n_wr;
            end
            if (do_pop) begin
                r_rd <= n_rd;
            end
            if (do_push && !do_pop) begin
                r_num <= r_num + 1'b1;
            end else if (do_pop && !do_push) begin
                r_num <= r_num - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/b32enc_back.sv
// Back part: sends the codes of the head group one per beat through an output register.
`default_nettype none

module b32enc_back import b32enc_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_grp          i_head,
    input  t_qstat        i_qstat,
    output logic          o_pop,
    b32enc_sym_if.source  o_sym
);

    logic [1:0] r_idx;
    logic       r_vld;
    logic [7:0] r_sym;
    logic       r_last;
    logic [1:0] n_idx;

    logic       load;
    logic       at_end;
    t_code      code;

    always_comb begin
        load   = !i_qstat.empty && (!r_vld || o_sym.ready);
        at_end = (r_idx == (i_head.num - 2'd1));
        code   = i_head.codes[r_idx];
        o_pop  = load && at_end;
        n_idx  = at_end ? 2'd0 : r_idx + 2'd1;

        o_sym.valid       = r_vld;
        o_sym.symbol      = r_sym;
        o_sym.last_symbol = r_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 2'd0;
            r_vld <= 1'b0;
        end else begin
            if (load) begin
                r_idx <= n_idx;
                r_vld <= 1'b1;
            end else if (o_sym.ready) begin
                r_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_sym  <= f_ascii(code);
            r_last <= i_head.last && at_end;
        end
    end

endmodule

`default_nettype wire

>>> rtl/base32_byte_encoder_unit.sv
// Top level of the base32 byte encoder: front part, code queue and back part.
//
// The block turns a byte stream into base32 text (alphabet A-Z then 2-7, sent as
// ASCII, no '=' padding). Every beat on i_byte carries one byte and a flag that
// marks the last byte of a message; every beat on o_sym carries one character and
// a flag on the last character of the message. Bits are taken most significant
// first, and up to four leftover bits wait between bytes. On the final byte a
// partial group is filled with zero bits on the right and sent, and the leftover
// store is emptied so the next byte starts a new message. A byte gives one or two
// characters (two or three when it is final). The output register sends one
// character per cycle while the receiver is ready, and that single output port
// sets the rate. A byte is taken in the cycle after the previous one whenever the
// code queue (QueueDepth groups) has room, even while a character waits on a
// stalled output. A taken byte's codes are written into the code queue, and its
// first character is then loaded into the output register once the output side
// is free. There is no configuration and no clearing pass after reset.
`default_nettype none

module base32_byte_encoder_unit import b32enc_pkg::*; #(
    parameter int unsigned QueueDepth = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    b32enc_byte_if.sink  i_byte,
    b32enc_sym_if.source o_sym
);

    // Groups of codes travel from the front part to the back part through the queue.
    t_grp   front_grp;
    t_grp   head_grp;
    t_qstat qstat;
    logic   push;
    logic   pop;

    // The front part keeps the leftover bits and splits each byte into codes.
    b32enc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (i_byte),
        .i_qstat (qstat),
        .o_push  (push),
        .o_grp   (front_grp)
    );

    // The queue lets the front take new bytes while the back part is stalled.
    b32enc_fifo #(
        .Depth (QueueDepth)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_grp   (front_grp),
        .i_pop   (pop),
        .o_head  (head_grp),
        .o_qstat (qstat)
    );

    // The back part maps one code per beat to its character and holds it until taken.
    b32enc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head_grp),
        .i_qstat (qstat),
        .o_pop   (pop),
        .o_sym   (o_sym)
    );

endmodule

`default_nettype wire

>>> rtl/b32enc_chk.sv
// Port checker for the base32 byte encoder and its bind to the top level.
`default_nettype none

module b32enc_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_sym_valid,
    input logic       i_sym_ready,
    input logic [7:0] i_symbol,
    input logic       i_last_symbol
);

`include "base32_byte_encoder_unit_assert.svh"

    // A character on the output is always one of the base32 alphabet.
    `B32_ASSERT_NOW(a_sym_alphabet, i_sym_valid, ((i_symbol >= 8'h41) && (i_symbol <= 8'h5A)) || ((i_symbol >= 8'h32) && (i_symbol <= 8'h37)), "symbol outside the base32 alphabet")

    // A stalled character stays in place with its flag.
    `B32_ASSERT_NEXT(a_sym_hold, i_sym_valid && !i_sym_ready, i_sym_valid && $stable(i_symbol) && $stable(i_last_symbol), "stalled symbol changed")

    // Nothing is offered in the first cycle out of reset.
    `B32_ASSERT_NOW(a_reset_quiet, $rose(i_rst_n), !i_sym_valid, "symbol offered right after reset")

endmodule

bind base32_byte_encoder_unit b32enc_chk u_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_sym_valid   (o_sym.valid),
    .i_sym_ready   (o_sym.ready),
    .i_symbol      (o_sym.symbol),
    .i_last_symbol (o_sym.last_symbol)
);

`default_nettype wire

>>> tb/base32_byte_encoder_unit_test.sv
// Self-checking testbench that encodes byte messages and checks the base32 characters.
`default_nettype none

module base32_byte_encoder_unit_test;

    localparam int unsigned CycleLimit = 50000;
    localparam int unsigned IdlePct    = 13;
    localparam int unsigned RandTarget = 200;
    localparam int unsigned HoldCycles = 80;

    // Alphabet with the character for code 0 in the top byte.
    localparam logic [8*32-1:0] B32Chars = "ABCDEFGHIJKLMNOPQRSTUVWXYZ234567";

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } t_byte_beat;

    typedef struct packed {
        logic [7:0] symbol;
        logic       last_symbol;
    } t_sym_beat;

    logic i_clk;
    logic i_rst_n;

    b32enc_byte_if byte_ch ();
    b32enc_sym_if  sym_ch ();

    base32_byte_encoder_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (byte_ch),
        .o_sym   (sym_ch)
    );

    t_byte_beat  bytes_to_send[$];
    t_sym_beat   sym_expected[$];

    // Encoder state as the predictor sees it: right-aligned leftover bits.
    logic [3:0]  carry_bits;
    int unsigned carry_count;

    int unsigned bytes_total;
    int unsigned bytes_taken;
    int unsigned messages_total;
    int unsigned symbols_seen;
    int unsigned error_count;
    int unsigned cycle_count;
    int unsigned hold_left;
    bit          hold_done;
    bit          sender_busy;
    bit          sender_calm;
    bit          receiver_calm;
    t_byte_beat  next_beat;
    t_sym_beat   want;

    function automatic logic [7:0] b32_char(input int unsigned code);
        return B32Chars[8*(31-code) +: 8];
    endfunction

    // Appends the characters caused by one accepted byte and moves the leftover bits.
    function automatic void encode_byte(input logic [7:0] data, input logic fin);
        int unsigned acc;
        int unsigned nbits;
        t_sym_beat   s;
        acc   = (int'(carry_bits) << 8) | int'(data);
        nbits = carry_count + 8;
        while (nbits >= 5) begin
            nbits -= 5;
            s.symbol      = b32_char((acc >> nbits) & 5'h1F);
            s.last_symbol = 1'b0;
            sym_expected.push_back(s);
        end
        acc &= (1 << nbits) - 1;
        if (fin) begin
            if (nbits > 0) begin
                s.symbol      = b32_char((acc << (5 - nbits)) & 5'h1F);
                s.last_symbol = 1'b0;
                sym_expected.push_back(s);
            end
            sym_expected[sym_expected.size()-1].last_symbol = 1'b1;
            carry_bits  = 4'd0;
            carry_count = 0;
        end else begin
            carry_bits  = acc[3:0];
            carry_count = nbits;
        end
    endfunction

    task automatic add_byte(input logic [7:0] data, input logic fin);
        t_byte_beat b;
        b.data_byte  = data;
        b.final_byte = fin;
        bytes_to_send.push_back(b);
        bytes_total++;
        if (fin) begin
            messages_total++;
        end
    endtask

    task automatic add_text(input string text);
        for (int i = 0; i < text.len(); i++) begin
            add_byte(text[i], i == text.len() - 1);
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Sender: offers the queued bytes, predicting the characters of each accepted beat.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            byte_ch.valid <= 1'b0;
        end else begin
            sender_busy = byte_ch.valid;
            if (byte_ch.valid && byte_ch.ready) begin
                encode_byte(byte_ch.data_byte, byte_ch.final_byte);
                bytes_taken++;
                sender_busy = 1'b0;
            end
            if (!sender_busy) begin
                sender_calm = (bytes_taken >= 120) && (bytes_taken < 170);
                if (bytes_to_send.size() > 0 &&
                    (sender_calm || $urandom_range(0, 99) >= IdlePct)) begin
                    next_beat = bytes_to_send.pop_front();
                    byte_ch.valid      <= 1'b1;
                    byte_ch.data_byte  <= next_beat.data_byte;
                    byte_ch.final_byte <= next_beat.final_byte;
                end else begin
                    byte_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks every character beat against the oldest prediction.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sym_ch.ready <= 1'b0;
        end else begin
            if (sym_ch.valid && sym_ch.ready) begin
                if (sym_expected.size() == 0) begin
                    $error("symbol 0x%02h arrived with no character predicted", sym_ch.symbol);
                    error_count++;
                end else begin
                    want = sym_expected.pop_front();
                    if (sym_ch.symbol !== want.symbol) begin
                        $error("symbol: expected 0x%02h, got 0x%02h",
                               want.symbol, sym_ch.symbol);
                        error_count++;
                    end
                    if (sym_ch.last_symbol !== want.last_symbol) begin
                        $error("last_symbol: expected %0b, got %0b",
                               want.last_symbol, sym_ch.last_symbol);
                        error_count++;
                    end
                end
                symbols_seen++;
            end
            receiver_calm = (symbols_seen >= 250) && (symbols_seen < 330);
            if (hold_left > 0) begin
                hold_left--;
                sym_ch.ready <= 1'b0;
            end else if (!hold_done && symbols_seen >= 30) begin
                // One long hold-off while the sender keeps offering bytes.
                hold_done = 1'b1;
                hold_left = HoldCycles;
                sym_ch.ready <= 1'b0;
            end else begin
                sym_ch.ready <= receiver_calm || ($urandom_range(0, 99) >= IdlePct);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("timeout after %0d cycles, %0d characters still predicted",
                     cycle_count, sym_expected.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        int unsigned len;
        byte_ch.valid      = 1'b0;
        byte_ch.data_byte  = 8'h00;
        byte_ch.final_byte = 1'b0;
        sym_ch.ready       = 1'b0;
        carry_bits         = 4'd0;
        carry_count        = 0;
        bytes_total        = 0;
        bytes_taken        = 0;
        messages_total     = 0;
        symbols_seen       = 0;
        error_count        = 0;
        cycle_count        = 0;
        hold_left          = 0;
        hold_done          = 1'b0;
        i_rst_n            = 1'b0;

        // Directed messages: all-zero and all-one bytes, then every leftover count
        // on the final byte, including an exact fit with no padded character and
        // a final byte that gives three characters.
        add_byte(8'h00, 1'b1);
        add_byte(8'hFF, 1'b1);
        add_text("f");
        add_text("fo");
        add_text("foo");
        add_text("foob");
        add_text("fooba");
        add_text("foobar");

        // Random messages, mostly short, every one closed by a final byte.
        while (bytes_total < RandTarget) begin
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 16) : $urandom_range(1, 5);
            for (int i = 0; i < len; i++) begin
                add_byte(8'($urandom_range(0, 255)), i == len - 1);
            end
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (bytes_taken < bytes_total) @(negedge i_clk);
        while (sym_expected.size() > 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);

        $display("encoded %0d bytes in %0d messages, checked %0d characters",
                 bytes_taken, messages_total, symbols_seen);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire
